// ===== rtl/core/ccw_pkg.sv =====
// Package for the coin change way counter: sizes, register reset values,
// the control state type and the structs between the top level and the table.
// No dependencies.
package ccw_pkg;

  // Configuration and sizes.
  localparam int NUM_COINS   = 4;
  localparam int MAX_AMOUNT  = 1023;
  localparam int COIN_REGS   = 4;
  localparam int NUM_SLOTS   = (NUM_COINS < COIN_REGS) ? NUM_COINS : COIN_REGS;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CFG_IDX_W   = $clog2(COIN_REGS);
  localparam int VALUE_W     = 10;
  localparam int COUNT_W     = 32;
  localparam int TABLE_DEPTH = MAX_AMOUNT + 1;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W     = COUNT_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [VALUE_W-1:0] COIN_RESET [COIN_REGS] = '{
    VALUE_W'(1), VALUE_W'(2), VALUE_W'(5), VALUE_W'(0)
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_SWEEP,
    S_FINISH
  } ccw_state_t;

  // Command from the sequencer to the table, one per cycle.
  typedef struct packed {
    logic              clr;       // write the initial value at addr
    logic              rmw;       // table[addr] += table[src_addr]
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] src_addr;
  } ccw_cmd_t;

  // Write that the table performs in this cycle, plus pipeline status.
  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_count;
    logic               wr_over;
    logic               busy;
  } ccw_stat_t;

endpackage

// ===== rtl/core/ccw_table.sv =====
// Way table of the coin change way counter: the scratch memory with two read
// ports, the saturating read-modify-write stage and write-to-read forwarding.
// Depends on ccw_pkg.
module ccw_table (
  input  logic             clk,
  input  logic             rst_n,
  input  ccw_pkg::ccw_cmd_t  cmd,
  output ccw_pkg::ccw_stat_t stat
);

  logic [ccw_pkg::ENTRY_W-1:0] mem [ccw_pkg::TABLE_DEPTH];

  logic [ccw_pkg::ENTRY_W-1:0] rd_a_r;
  logic [ccw_pkg::ENTRY_W-1:0] rd_b_r;
  logic                        fwd_a_r;
  logic                        fwd_b_r;
  logic [ccw_pkg::ENTRY_W-1:0] fwd_data_r;
  logic [ccw_pkg::ADDR_W-1:0]  b_addr_r;
  logic                        b_valid_r;

  logic [ccw_pkg::ENTRY_W-1:0] op_a;
  logic [ccw_pkg::ENTRY_W-1:0] op_b;
  logic [ccw_pkg::COUNT_W:0]   sum;
  logic [ccw_pkg::COUNT_W-1:0] sum_sat;
  logic                        sum_over;

  logic                        wr_en;
  logic [ccw_pkg::ADDR_W-1:0]  wr_addr;
  logic [ccw_pkg::ENTRY_W-1:0] wr_data;

  // Update stage: operands come from the memory, or from the write of the
  // previous cycle when the read hit the entry that was being written.
  assign op_a     = fwd_a_r ? fwd_data_r : rd_a_r;
  assign op_b     = fwd_b_r ? fwd_data_r : rd_b_r;
  assign sum      = {1'b0, op_a[ccw_pkg::COUNT_W-1:0]} + {1'b0, op_b[ccw_pkg::COUNT_W-1:0]};
  assign sum_over = op_a[ccw_pkg::COUNT_W] | op_b[ccw_pkg::COUNT_W] | sum[ccw_pkg::COUNT_W];
  assign sum_sat  = sum[ccw_pkg::COUNT_W] ? ccw_pkg::COUNT_MAX : sum[ccw_pkg::COUNT_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = b_addr_r;
    wr_data = {sum_over, sum_sat};
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = cmd.addr;
      wr_data = {1'b0, (cmd.addr == '0) ? ccw_pkg::COUNT_W'(1) : '0};
    end else if (b_valid_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r     <= mem[cmd.addr];
    rd_b_r     <= mem[cmd.src_addr];
    fwd_a_r    <= wr_en && (wr_addr == cmd.addr);
    fwd_b_r    <= wr_en && (wr_addr == cmd.src_addr);
    fwd_data_r <= wr_data;
    b_addr_r   <= cmd.addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= cmd.rmw;
    end
  end

  assign stat.wr_en    = wr_en;
  assign stat.wr_addr  = wr_addr;
  assign stat.wr_count = wr_data[ccw_pkg::COUNT_W-1:0];
  assign stat.wr_over  = wr_data[ccw_pkg::COUNT_W];
  assign stat.busy     = b_valid_r;

  // A clear write never competes with a pending update.
  a_clr_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr && b_valid_r))
    else $error("clear write collides with a pending update");

  // An update reads an entry at or below the one it writes.
  a_src_below: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rmw |-> (cmd.src_addr <= cmd.addr))
    else $error("update source lies above its destination");

  // The update stage only runs the cycle after an issued update.
  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> $past(cmd.rmw))
    else $error("update stage active without an issued update");

endmodule

// ===== rtl/core/coin_change_way_counter_unit.sv =====
// Coin change way counter, top level: request handshakes, coin registers and
// the sequencer that sweeps the way table. Depends on ccw_pkg and ccw_table.
//
// For each request the block returns how many unordered combinations of the
// configured coin values (four 10-bit registers, zero meaning an unused slot)
// add up exactly to in_target_amount, with out_count_saturated set when the
// count ran past 32 bits and out_way_count then held at all ones. The work
// lives in one 1024-entry way table, a single memory with two registered read
// ports. A request first clears entries 0 through the target, then for every
// live coin c (nonzero and not above the target) sweeps the entries from c up
// to the target, one read-add-write per cycle with forwarding from the write
// of the cycle before; a coin that is unused or too large is skipped. The
// result is handed over once the update stage has drained and the output
// register is free. One request is worked on at a time: in_stall is high from
// acceptance until the result has been moved to the output register, and a
// finished result waits there while the next request is being taken. A target
// amount of zero gives a count of one.
// Coin registers may be written only while the block is idle.
module coin_change_way_counter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ccw_pkg::VALUE_W-1:0]    in_target_amount,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ccw_pkg::COUNT_W-1:0]    out_way_count,
  output logic                           out_count_saturated,
  // Configuration port.
  input  logic                           cfg_wr_en,
  input  logic [ccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccw_pkg::VALUE_W-1:0]    cfg_wdata
);

  ccw_pkg::ccw_state_t state_r, state_nxt;

  logic [ccw_pkg::VALUE_W-1:0] coin_r [ccw_pkg::COIN_REGS];

  logic [ccw_pkg::ADDR_W-1:0]  target_r, target_nxt;
  logic [ccw_pkg::ADDR_W-1:0]  j_r, j_nxt;
  logic [ccw_pkg::SLOT_W-1:0]  k_r, k_nxt;
  logic [ccw_pkg::COUNT_W-1:0] result_count_r, result_count_nxt;
  logic                        result_sat_r, result_sat_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ccw_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                        out_sat_r, out_sat_nxt;

  ccw_pkg::ccw_cmd_t  cmd;
  ccw_pkg::ccw_stat_t stat;

  logic [ccw_pkg::VALUE_W-1:0] coin_cur;
  logic [ccw_pkg::VALUE_W-1:0] coin_next;
  logic                        coin_live;
  logic                        last_slot;
  logic                        in_acc;
  logic                        in_range;
  logic                        out_free;
  logic                        done;

  ccw_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  assign coin_cur  = coin_r[k_r];
  assign last_slot = (k_r == ccw_pkg::SLOT_W'(ccw_pkg::NUM_SLOTS - 1));
  // The next slot is only looked at when the current one is not the last.
  assign coin_next = last_slot ? coin_cur : coin_r[ccw_pkg::SLOT_W'(k_r + 1'b1)];
  assign coin_live = (coin_cur != '0) && (32'(coin_cur) <= 32'(target_r));

  assign in_stall = (state_r != ccw_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = (32'(in_target_amount) <= 32'(ccw_pkg::MAX_AMOUNT));
  assign out_free = !out_valid_r || !out_stall;
  // Finish once the update stage has drained and the output register is free.
  assign done     = (state_r == ccw_pkg::S_FINISH) && !stat.busy && out_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccw_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_range ? ccw_pkg::S_CLEAR : ccw_pkg::S_FINISH;
        end
      end
      ccw_pkg::S_CLEAR: begin
        if (j_r == target_r) begin
          state_nxt = ccw_pkg::S_SWEEP;
        end
      end
      ccw_pkg::S_SWEEP: begin
        if ((!coin_live || (j_r == target_r)) && last_slot) begin
          state_nxt = ccw_pkg::S_FINISH;
        end
      end
      ccw_pkg::S_FINISH: begin
        if (done) begin
          state_nxt = ccw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ccw_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs, table commands and result handling.
  always_comb begin
    target_nxt       = target_r;
    j_nxt            = j_r;
    k_nxt            = k_r;
    result_count_nxt = result_count_r;
    result_sat_nxt   = result_sat_r;
    out_valid_nxt    = out_valid_r;
    out_count_nxt    = out_count_r;
    out_sat_nxt      = out_sat_r;
    cmd              = '0;
    cmd.addr         = j_r;
    cmd.src_addr     = j_r - ccw_pkg::ADDR_W'(coin_cur);

    case (state_r)
      ccw_pkg::S_IDLE: begin
        if (in_acc) begin
          // An amount beyond the table answers zero without any sweep.
          target_nxt       = ccw_pkg::ADDR_W'(in_target_amount);
          j_nxt            = '0;
          k_nxt            = '0;
          result_count_nxt = '0;
          result_sat_nxt   = 1'b0;
        end
      end
      ccw_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (j_r == target_r) begin
          k_nxt = '0;
          j_nxt = ccw_pkg::ADDR_W'(coin_r[0]);
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ccw_pkg::S_SWEEP: begin
        if (coin_live) begin
          cmd.rmw = 1'b1;
        end
        if (!coin_live || (j_r == target_r)) begin
          if (!last_slot) begin
            k_nxt = ccw_pkg::SLOT_W'(k_r + 1'b1);
            j_nxt = ccw_pkg::ADDR_W'(coin_next);
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ccw_pkg::S_FINISH: begin
      end
      default: begin
      end
    endcase

    // Every clear pass and every sweep ends at the target, so the last write
    // to the target entry is the answer.
    if (stat.wr_en && (stat.wr_addr == target_r)) begin
      result_count_nxt = stat.wr_count;
      result_sat_nxt   = stat.wr_over;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = result_count_r;
      out_sat_nxt   = result_sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccw_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      for (int i = 0; i < ccw_pkg::COIN_REGS; i++) begin
        coin_r[i] <= ccw_pkg::COIN_RESET[i];
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      if (cfg_wr_en && (32'(cfg_index) < ccw_pkg::COIN_REGS)) begin
        coin_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    target_r       <= target_nxt;
    result_count_r <= result_count_nxt;
    result_sat_r   <= result_sat_nxt;
    out_count_r    <= out_count_nxt;
    out_sat_r      <= out_sat_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_way_count       = out_count_r;
  assign out_count_saturated = out_sat_r;

  // While waiting to hand over a result the table is left alone.
  a_finish_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccw_pkg::S_FINISH) |-> (!cmd.clr && !cmd.rmw))
    else $error("table command issued while finishing");

  // A sweep never runs past the target entry.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rmw || cmd.clr) |-> (j_r <= target_r))
    else $error("table access beyond the target");

  // A result only appears when a request finishes.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ccw_pkg::S_FINISH))
    else $error("result presented without a finished request");

endmodule
